// File: rtl/akd_pkg.sv
// Shared types and constants for the ladder keypad debouncer.
// Holds the voltage window table, the register indexes and the result struct.
// Depends on nothing.
package akd_pkg;

    // Field and counter widths.
    localparam int ADC_W         = 12;
    localparam int VOL_W         = 7;
    localparam int LVL_W         = 16;
    localparam int KEY_W         = 3;
    localparam int DIV_W         = 9;
    localparam int CFG_IDX_W     = 1;
    localparam int KEY_COUNT_DEF = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_LEVEL = 1'd1;

    // Register reset values.
    localparam logic [LVL_W-1:0] FLOOR_RESET  = 16'd0;
    localparam logic [LVL_W-1:0] ACCEPT_RESET = 16'd100;

    // A sample at or above this level means no key is pressed.
    localparam logic [ADC_W-1:0] RELEASE_THRESHOLD = 12'd3900;

    // Key windows: the lower bound is excluded, the upper bound included.
    localparam logic [ADC_W-1:0] WIN_LOW [KEY_COUNT_DEF] = '{
        12'd1, 12'd750, 12'd1300, 12'd1800, 12'd2400, 12'd3000, 12'd3500
    };
    localparam logic [ADC_W-1:0] WIN_HIGH [KEY_COUNT_DEF] = '{
        12'd500, 12'd1250, 12'd1800, 12'd2300, 12'd2900, 12'd3400, 12'd3900
    };

    // Tone prescaler is the base plus one step per key.
    localparam logic [DIV_W-1:0] DIV_BASE = 9'd125;
    localparam logic [DIV_W-1:0] DIV_STEP = 9'd25;

    // One result item.
    typedef struct packed {
        logic             key_active;
        logic             tone_valid;
        logic [KEY_W-1:0] key_number;
        logic [DIV_W-1:0] tone_divider;
        logic [VOL_W-1:0] duty;
    } t_result;

    // Prescaler for a given key number.
    function automatic logic [DIV_W-1:0] tone_div(input logic [KEY_W-1:0] key);
        logic [DIV_W-1:0] key_ext;
        key_ext = {{(DIV_W-KEY_W){1'b0}}, key};
        return DIV_W'(DIV_BASE + DIV_W'(DIV_STEP * key_ext));
    endfunction

endpackage

// File: rtl/akd_bank.sv
// Integrator bank of the ladder keypad debouncer: window match, counter update
// and result formation for one sample. Depends on akd_pkg.
module akd_bank
    import akd_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [ADC_W-1:0] i_adc_sample,
    input  logic [VOL_W-1:0] i_sound_level,
    input  logic [LVL_W-1:0] i_floor_level,
    input  logic [LVL_W-1:0] i_accept_level,
    output t_result          o_result
);

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [LVL_W-1:0] r_integ [KEY_COUNT];
    logic [LVL_W-1:0] n_integ [KEY_COUNT];
    logic [LVL_W-1:0] dec_lvl [KEY_COUNT];

    logic [KEY_COUNT-1:0] hit;
    logic                 any_hit;
    logic [IDX_W-1:0]     sel;
    logic                 active;
    logic [LVL_W-1:0]     cur_lvl;
    logic [LVL_W-1:0]     inc_lvl;
    logic                 up_hit;
    logic [KEY_W-1:0]     key_num;

    // Match the sample against each window; the lowest matching key wins.
    always_comb begin
        sel = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            hit[k] = (i_adc_sample > WIN_LOW[k]) && (i_adc_sample <= WIN_HIGH[k]);
        end
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (hit[k]) begin
                sel = IDX_W'(k);
            end
        end
        any_hit = |hit;
        active  = i_adc_sample < RELEASE_THRESHOLD;
        key_num = KEY_W'(sel);
    end

    // Count-up path for the selected key, saturating at all ones.
    always_comb begin
        cur_lvl = r_integ[sel];
        inc_lvl = (cur_lvl == {LVL_W{1'b1}}) ? cur_lvl : LVL_W'(cur_lvl + 1'b1);
        up_hit  = inc_lvl >= i_accept_level;
    end

    // Count-down path for every key: floor first, then the acceptance clamp.
    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            dec_lvl[k] = (r_integ[k] == '0) ? '0 : LVL_W'(r_integ[k] - 1'b1);
            if (dec_lvl[k] <= i_floor_level) begin
                dec_lvl[k] = i_floor_level;
            end
            if (dec_lvl[k] >= i_accept_level) begin
                dec_lvl[k] = i_accept_level;
            end
        end
    end

    // Next integrator values.
    always_comb begin
        for (int k = 0; k < KEY_COUNT; k++) begin
            n_integ[k] = r_integ[k];
            if (!active) begin
                n_integ[k] = dec_lvl[k];
            end else if (any_hit && (sel == IDX_W'(k))) begin
                n_integ[k] = up_hit ? i_accept_level : inc_lvl;
            end
        end
    end

    // Integrators start at the reset floor level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_integ[k] <= FLOOR_RESET;
            end
        end else if (i_step) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_integ[k] <= n_integ[k];
            end
        end
    end

    // Result fields other than key_active are zero unless a press is accepted.
    always_comb begin
        o_result            = '0;
        o_result.key_active = active;
        if (active && any_hit && up_hit) begin
            o_result.tone_valid   = 1'b1;
            o_result.key_number   = key_num;
            o_result.tone_divider = tone_div(key_num);
            o_result.duty         = i_sound_level;
        end
    end

endmodule

// File: rtl/adc_ladder_keypad_debouncer.sv
// Ladder keypad debouncer top level. A sample passes through the input register,
// then the result register, before its result is offered.
// Throughput: one sample per cycle while the result channel does not stall; the
// integrator update is a single pass through the bank between those two registers.
// Reset: synchronous, active low; clears both stages, sets floor_level to 0,
// accept_level to 100 and every integrator to 0.
module adc_ladder_keypad_debouncer
    import akd_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Sample channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ADC_W-1:0]     i_adc_sample,
    input  logic [VOL_W-1:0]     i_sound_level,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_key_active,
    output logic                 o_tone_valid,
    output logic [KEY_W-1:0]     o_key_number,
    output logic [DIV_W-1:0]     o_tone_divider,
    output logic [VOL_W-1:0]     o_duty,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LVL_W-1:0]     i_cfg_data
);

    logic             r_in_valid;
    logic [ADC_W-1:0] r_in_sample;
    logic [VOL_W-1:0] r_in_sound;
    logic             r_out_valid;
    t_result          r_out;
    logic [LVL_W-1:0] r_floor_level;
    logic [LVL_W-1:0] r_accept_level;

    logic    advance;
    logic    in_take;
    t_result bank_result;

    // Handshake: the input stage advances when the result register is free
    // or its result is transferred in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor_level  <= FLOOR_RESET;
            r_accept_level <= ACCEPT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FLOOR_LEVEL:  r_floor_level  <= i_cfg_data;
                REG_ACCEPT_LEVEL: r_accept_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_adc_sample;
            r_in_sound  <= i_sound_level;
        end
    end

    // Integrator bank works on the registered sample.
    akd_bank #(
        .KEY_COUNT (KEY_COUNT)
    ) u_bank (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_adc_sample   (r_in_sample),
        .i_sound_level  (r_in_sound),
        .i_floor_level  (r_floor_level),
        .i_accept_level (r_accept_level),
        .o_result       (bank_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= bank_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_key_active   = r_out.key_active;
    assign o_tone_valid   = r_out.tone_valid;
    assign o_key_number   = r_out.key_number;
    assign o_tone_divider = r_out.tone_divider;
    assign o_duty         = r_out.duty;

endmodule

// File: dv/adc_ladder_keypad_debouncer_tb.sv
// Self-checking testbench for the ladder keypad debouncer.
// It drives samples in bursts, stalls results at random and checks each result against
// an in-bench integrator model. Depends on akd_pkg and adc_ladder_keypad_debouncer.
`timescale 1ns / 1ps

module adc_ladder_keypad_debouncer_tb;
    import akd_pkg::*;

    // One sample transfer as queued for the driver.
    typedef struct {
        logic [ADC_W-1:0] sample;
        logic [VOL_W-1:0] volume;
    } t_sample_item;

    // Receiver stall patterns.
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_mode;

    // Clock, reset and block inputs, all known from time zero.
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [ADC_W-1:0]     i_adc_sample  = '0;
    logic [VOL_W-1:0]     i_sound_level = '0;
    logic                 i_out_stall   = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = REG_FLOOR_LEVEL;
    logic [LVL_W-1:0]     i_cfg_data    = '0;

    // Block outputs.
    logic             o_in_stall;
    logic             o_out_valid;
    logic             o_key_active;
    logic             o_tone_valid;
    logic [KEY_W-1:0] o_key_number;
    logic [DIV_W-1:0] o_tone_divider;
    logic [VOL_W-1:0] o_duty;
    logic             o_cfg_ready;

    // Integrator model and its levels.
    logic [LVL_W-1:0] model_floor;
    logic [LVL_W-1:0] model_accept;
    logic [LVL_W-1:0] model_integ [KEY_COUNT_DEF];

    // Stimulus and expected-result stores.
    t_sample_item pending_samples[$];
    t_result      expected_results[$];

    // Progress counters.
    int n_queued    = 0;
    int n_taken     = 0;
    int n_checked   = 0;
    int n_accepts   = 0;
    int n_settings  = 0;
    int n_errors    = 0;
    logic in_taken  = 1'b0;

    // Sender and receiver pacing.
    int          burst_left = 1;
    int          gap_left   = 0;
    int          stall_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    adc_ladder_keypad_debouncer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_adc_sample   (i_adc_sample),
        .i_sound_level  (i_sound_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_key_active   (o_key_active),
        .o_tone_valid   (o_tone_valid),
        .o_key_number   (o_key_number),
        .o_tone_divider (o_tone_divider),
        .o_duty         (o_duty),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Free-running clock.
    always #5 i_clk = ~i_clk;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        n_errors++;
    endtask

    // Advances the integrator model by one sample and returns the result it implies.
    function automatic t_result predict_keypad(input logic [ADC_W-1:0] sample,
                                               input logic [VOL_W-1:0] volume);
        t_result res;
        int      key;
        int      lvl;
        res = '0;
        key = -1;
        if (sample < RELEASE_THRESHOLD) begin
            res.key_active = 1'b1;
            // The lowest matching window wins where two windows share a bound.
            for (int k = KEY_COUNT_DEF - 1; k >= 0; k--) begin
                if (sample > WIN_LOW[k] && sample <= WIN_HIGH[k]) key = k;
            end
            if (key >= 0) begin
                lvl = model_integ[key];
                if (lvl < 65535) lvl++;
                if (lvl >= model_accept) begin
                    lvl              = model_accept;
                    res.tone_valid   = 1'b1;
                    res.key_number   = KEY_W'(key);
                    res.tone_divider = DIV_W'(int'(DIV_BASE) + int'(DIV_STEP) * key);
                    res.duty         = volume;
                end
                model_integ[key] = LVL_W'(lvl);
            end
        end else begin
            // Release: every integrator leaks down to the floor, then the clamp applies.
            for (int k = 0; k < KEY_COUNT_DEF; k++) begin
                lvl = model_integ[k];
                if (lvl > 0) lvl--;
                if (lvl <= model_floor) lvl = model_floor;
                if (lvl >= model_accept) lvl = model_accept;
                model_integ[k] = LVL_W'(lvl);
            end
        end
        return res;
    endfunction

    // Sample driver: bursts of transfers separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // Stalled: hold the payload.
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
            t_sample_item item;
            item = pending_samples.pop_front();
            i_in_valid    <= 1'b1;
            i_adc_sample  <= item.sample;
            i_sound_level <= item.volume;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = $urandom_range(1, 6);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Result stall pattern: stretches with no stall, light stalls and heavy stalls.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            default:     i_out_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // Monitor: tracks register writes, predicts on each sample transfer, checks results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken     <= 1'b0;
            model_floor  = FLOOR_RESET;
            model_accept = ACCEPT_RESET;
            for (int k = 0; k < KEY_COUNT_DEF; k++) model_integ[k] = '0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_FLOOR_LEVEL) model_floor = i_cfg_data;
                else if (i_cfg_index == REG_ACCEPT_LEVEL) model_accept = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(predict_keypad(i_adc_sample, i_sound_level));
                n_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    t_result want;
                    want = expected_results.pop_front();
                    n_checked++;
                    if (want.tone_valid) n_accepts++;
                    if (o_key_active !== want.key_active)
                        report_mismatch("key_active", o_key_active, want.key_active);
                    if (o_tone_valid !== want.tone_valid)
                        report_mismatch("tone_valid", o_tone_valid, want.tone_valid);
                    if (o_key_number !== want.key_number)
                        report_mismatch("key_number", o_key_number, want.key_number);
                    if (o_tone_divider !== want.tone_divider)
                        report_mismatch("tone_divider", o_tone_divider, want.tone_divider);
                    if (o_duty !== want.duty)
                        report_mismatch("duty", o_duty, want.duty);
                end
            end
        end
    end

    // Stimulus helpers.
    task automatic queue_sample(input int sample, input int volume);
        t_sample_item item;
        item.sample = ADC_W'(sample);
        item.volume = VOL_W'(volume);
        pending_samples.push_back(item);
        n_queued++;
    endtask

    function automatic int rand_volume();
        if ($urandom_range(0, 9) == 0) return $urandom_range(101, 127);
        return $urandom_range(0, 100);
    endfunction

    function automatic int window_sample(input int key);
        return $urandom_range(int'(WIN_LOW[key]) + 1, int'(WIN_HIGH[key]));
    endfunction

    function automatic int release_sample();
        return $urandom_range(int'(RELEASE_THRESHOLD), 4095);
    endfunction

    // An active sample that falls in no window.
    function automatic int gap_sample();
        int g;
        g = $urandom_range(0, KEY_COUNT_DEF - 1);
        if (g < KEY_COUNT_DEF - 1 && WIN_HIGH[g] < WIN_LOW[g + 1])
            return $urandom_range(int'(WIN_HIGH[g]) + 1, int'(WIN_LOW[g + 1]));
        return $urandom_range(0, int'(WIN_LOW[0]));
    endfunction

    // Mostly press-and-release sequences, with glitches and stray samples mixed in.
    task automatic queue_random(input int count, input int hold_max);
        int n;
        int key;
        int run;
        int pick;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                key = $urandom_range(0, KEY_COUNT_DEF - 1);
                run = $urandom_range(1, hold_max);
                for (int j = 0; j < run && n < count; j++, n++) begin
                    case ($urandom_range(0, 19))
                        0:       queue_sample(gap_sample(), rand_volume());
                        1:       queue_sample(release_sample(), rand_volume());
                        2:       queue_sample(window_sample($urandom_range(0, 6)), rand_volume());
                        default: queue_sample(window_sample(key), rand_volume());
                    endcase
                end
                run = $urandom_range(1, hold_max);
                for (int j = 0; j < run && n < count; j++, n++) begin
                    queue_sample(release_sample(), rand_volume());
                end
            end else if (pick < 90) begin
                queue_sample(gap_sample(), rand_volume());
                n++;
            end else begin
                queue_sample($urandom_range(0, 4095), $urandom_range(0, 127));
                n++;
            end
        end
    endtask

    // Waits until every queued sample is taken and every result checked.
    task automatic wait_drained();
        while (n_taken != n_queued || expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register transfer on the configuration channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [LVL_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_levels(input int floor_lvl, input int accept_lvl);
        wait_drained();
        write_reg(REG_FLOOR_LEVEL, LVL_W'(floor_lvl));
        write_reg(REG_ACCEPT_LEVEL, LVL_W'(accept_lvl));
        n_settings++;
    endtask

    // Window bounds, gaps, the release threshold and volume extremes.
    int directed_samples [25] = '{
        0, 1, 2, 500, 501, 750, 751, 1250, 1300, 1301, 1800, 1801, 2300,
        2400, 2401, 2900, 2901, 3001, 3400, 3401, 3501, 3899, 3900, 4095, 3899
    };

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset levels: long holds are needed to reach the default acceptance level.
        n_settings = 1;
        queue_random(150, 120);

        // Directed pass with a two-sample acceptance level.
        set_levels(0, 2);
        for (int i = 0; i < 25; i++) begin
            case (i % 4)
                0:       queue_sample(directed_samples[i], 0);
                1:       queue_sample(directed_samples[i], 127);
                2:       queue_sample(directed_samples[i], 100);
                default: queue_sample(directed_samples[i], $urandom_range(0, 127));
            endcase
        end

        // Random passes over a spread of level settings.
        set_levels(0, 1);
        queue_random(100, 4);
        set_levels(2, 6);
        queue_random(200, 10);
        // Floor above acceptance: after a release, every in-window sample is accepted.
        set_levels(50, 10);
        queue_random(60, 6);
        set_levels(0, 0);
        queue_random(40, 4);
        set_levels(65535, 65535);
        queue_random(40, 6);
        // Integrators keep their high values across this write.
        set_levels(0, 65535);
        queue_random(40, 6);
        set_levels(3, 12);
        queue_random(200, 20);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d results from %0d samples over %0d level settings.",
                 n_checked, n_taken, n_settings);
        $display("%0d results carried an accepted key.", n_accepts);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #2000000;
        $display("Timeout with %0d results still outstanding.", expected_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
